[rtl/core/vssc_pkg.sv]
// Package with payload types, state codes and fixed widths for the voxel tracer.
`timescale 1ns / 1ps
`default_nettype none
package vssc_pkg;

  typedef struct packed {
    logic              func;
    logic [4:0]        cell_x;
    logic [4:0]        cell_y;
    logic [4:0]        cell_z;
    logic              solid_bit;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] end_z;
    logic [5:0]        step_limit;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] hit_x;
    logic signed [7:0] hit_y;
    logic signed [7:0] hit_z;
    logic              is_hit;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_EMIT,
    ST_MARK
  } state_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TRACE = 1'b1;

  // Divider request from the sequencer to the shared divider.
  typedef struct packed {
    logic        start;
    logic [16:0] num;
    logic [16:0] den;
  } div_req_t;

endpackage
`default_nettype wire

[rtl/core/vssc_divider.sv]
// Shared restoring divider computing floor(num * 2^T_FRAC_BITS / den), saturated.
`timescale 1ns / 1ps
`default_nettype none
module vssc_divider #(
  parameter int T_FRAC_BITS = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire vssc_pkg::div_req_t       req,
  output logic                          busy,
  output logic [T_FRAC_BITS+7:0]        quot
);
  localparam int QW = T_FRAC_BITS + 17;
  localparam int TW = T_FRAC_BITS + 8;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] dividend;
  logic [QW-1:0] q;
  logic [17:0]   rem;
  logic [16:0]   den;
  logic [CW-1:0] count;
  logic [17:0]   trial;

  assign trial = {rem[16:0], dividend[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= CW'(QW);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= {req.num, {T_FRAC_BITS{1'b0}}};
      den      <= req.den;
      rem      <= '0;
      q        <= '0;
    end else if (busy) begin
      dividend <= {dividend[QW-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[QW-2:0], 1'b0};
      end
    end
  end

  assign quot = (|q[QW-1:TW]) ? {TW{1'b1}} : q[TW-1:0];
endmodule
`default_nettype wire

[rtl/core/vssc_occ_mem.sv]
// Occupancy bitmap memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module vssc_occ_mem #(
  parameter int AW = 15
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);
  logic mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/voxel_segment_solid_cells.sv]
// Top level of the voxel segment tracer: sequencer, setup and occupancy memory.
// A write is stored as it is accepted. A trace runs two divisions per moving axis and none for a
// still axis, then reads and checks each visited cell, emits a result per hit and an end marker,
// and returns to idle; with zero length or zero step limit it gives only the end marker. After
// reset a clearing pass writes all 2^(3*GRID_AXIS_BITS) voxels empty, one per cycle, while
// in_ready stays low. Output has a holding register; one item at a time.
`timescale 1ns / 1ps
`default_nettype none
module voxel_segment_solid_cells #(
  parameter int GRID_AXIS_BITS = 5,
  parameter int STEP_BOUND     = 63,
  parameter int T_FRAC_BITS    = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire vssc_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output vssc_pkg::out_item_t       out_data
);
  localparam int AW = 3 * GRID_AXIS_BITS;
  localparam int TW = T_FRAC_BITS + 8;
  localparam logic [TW-1:0] T_SAT = {TW{1'b1}};
  localparam logic [TW:0]   T_ONE = (TW+1)'(1) << T_FRAC_BITS;

  vssc_pkg::state_t state, state_next;
  vssc_pkg::in_item_t item;
  vssc_pkg::div_req_t dreq;

  logic          clearing;
  logic [AW:0]   clr_cnt;
  logic signed [8:0]  pos [3];
  logic signed [1:0]  stp [3];
  logic [TW-1:0] tmax [3];
  logic [TW-1:0] tdel [3];
  logic [1:0]    axis;
  logic          phase;
  logic [5:0]    left;
  logic          div_busy, div_issued;
  logic [TW-1:0] quot;
  logic          we, wdata, rdata;
  logic [AW-1:0] waddr, raddr;
  logic [GRID_AXIS_BITS-1:0] wx, wy, wz;
  logic          inside_g;
  logic [1:0]    pick;
  logic          far;
  logic [5:0]    lim;
  logic signed [16:0] d_ax;
  logic signed [15:0] s_ax, e_ax;
  logic signed [8:0]  c_ax;
  logic [16:0]   num_ax;
  logic          zero_len;
  logic [TW:0]   tsum;
  logic          div_done;

  assign in_ready = (state == vssc_pkg::ST_IDLE) && !clearing;

  always_comb begin
    case (axis)
      2'd0: begin s_ax = item.start_x; e_ax = item.end_x; end
      2'd1: begin s_ax = item.start_y; e_ax = item.end_y; end
      default: begin s_ax = item.start_z; e_ax = item.end_z; end
    endcase
    c_ax = 9'(s_ax >>> 8);
    d_ax = 17'(e_ax) - 17'(s_ax);
    if (d_ax > 0) num_ax = 17'(((18'(c_ax) + 18'sd1) <<< 8) - 18'(s_ax));
    else          num_ax = 17'(18'(s_ax) - (18'(c_ax) <<< 8));
    zero_len = (item.start_x == item.end_x) && (item.start_y == item.end_y) &&
               (item.start_z == item.end_z);
    lim = (item.step_limit > 6'(STEP_BOUND)) ? 6'(STEP_BOUND) : item.step_limit;
  end

  assign dreq.start = (state == vssc_pkg::ST_DIV) && !div_busy && !div_issued && d_ax != 0 &&
                      lim != 6'd0 && !zero_len;
  assign dreq.num   = phase ? 17'd256 : num_ax;
  assign dreq.den   = (d_ax < 0) ? 17'(-d_ax) : 17'(d_ax);
  assign div_done   = div_issued && !div_busy;

  vssc_divider #(.T_FRAC_BITS(T_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .req(dreq), .busy(div_busy), .quot(quot)
  );

  always_comb begin
    inside_g = 1'b1;
    for (int a = 0; a < 3; a++)
      if ((pos[a] >>> GRID_AXIS_BITS) != 9'sd0) inside_g = 1'b0;
    raddr = {pos[0][GRID_AXIS_BITS-1:0], pos[1][GRID_AXIS_BITS-1:0],
             pos[2][GRID_AXIS_BITS-1:0]};
    if (tmax[0] < tmax[1]) pick = (tmax[0] < tmax[2]) ? 2'd0 : 2'd2;
    else                   pick = (tmax[1] < tmax[2]) ? 2'd1 : 2'd2;
    far  = {1'b0, tmax[pick]} > T_ONE;
    tsum = {1'b0, tmax[pick]} + {1'b0, tdel[pick]};
  end

  assign wx = GRID_AXIS_BITS'(in_data.cell_x);
  assign wy = GRID_AXIS_BITS'(in_data.cell_y);
  assign wz = GRID_AXIS_BITS'(in_data.cell_z);

  always_comb begin
    we = 1'b0; waddr = clr_cnt[AW-1:0]; wdata = 1'b0;
    if (clearing) we = 1'b1;
    else if (in_valid && in_ready && in_data.func == vssc_pkg::FUNC_WRITE) begin
      we = 1'b1;
      waddr = {wx, wy, wz};
      wdata = in_data.solid_bit;
      if (GRID_AXIS_BITS < 5 && ((in_data.cell_x >> GRID_AXIS_BITS) != 0 ||
          (in_data.cell_y >> GRID_AXIS_BITS) != 0 || (in_data.cell_z >> GRID_AXIS_BITS) != 0))
        we = 1'b0;
    end
  end

  vssc_occ_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      vssc_pkg::ST_IDLE:
        if (in_valid && in_ready && in_data.func == vssc_pkg::FUNC_TRACE)
          state_next = vssc_pkg::ST_DIV;
      vssc_pkg::ST_DIV:
        if (lim == 6'd0 || zero_len) state_next = vssc_pkg::ST_MARK;
        else if (axis == 2'd2 && (d_ax == 0 || (phase && div_done)))
          state_next = vssc_pkg::ST_READ;
      vssc_pkg::ST_READ: state_next = vssc_pkg::ST_CHECK;
      vssc_pkg::ST_CHECK:
        if (inside_g && rdata) state_next = vssc_pkg::ST_EMIT;
        else if (far || left == 6'd1) state_next = vssc_pkg::ST_MARK;
        else state_next = vssc_pkg::ST_READ;
      vssc_pkg::ST_EMIT:
        if (!out_valid || out_ready)
          state_next = (far || left == 6'd1) ? vssc_pkg::ST_MARK : vssc_pkg::ST_READ;
      vssc_pkg::ST_MARK:
        if (!out_valid || out_ready) state_next = vssc_pkg::ST_IDLE;
      default: state_next = vssc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vssc_pkg::ST_IDLE;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      div_issued <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (AW+1)'((2**AW) - 1)) clearing <= 1'b0;
      end
      if ((state == vssc_pkg::ST_EMIT || state == vssc_pkg::ST_MARK) &&
          (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (dreq.start) div_issued <= 1'b1;
      else if (div_done) div_issued <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      vssc_pkg::ST_IDLE: begin
        item <= in_data;
        axis <= 2'd0;
        phase <= 1'b0;
        left <= (in_data.step_limit > 6'(STEP_BOUND)) ? 6'(STEP_BOUND) : in_data.step_limit;
        pos[0] <= 9'(in_data.start_x >>> 8);
        pos[1] <= 9'(in_data.start_y >>> 8);
        pos[2] <= 9'(in_data.start_z >>> 8);
      end
      vssc_pkg::ST_DIV: begin
        if (d_ax == 0 || div_done) begin
          if (d_ax == 0) begin
            tmax[axis] <= T_SAT; tdel[axis] <= T_SAT; stp[axis] <= 2'sd0;
          end else if (!phase) begin
            tmax[axis] <= quot; stp[axis] <= (d_ax > 0) ? 2'sd1 : -2'sd1;
          end else tdel[axis] <= quot;
          if (phase || d_ax == 0) begin
            phase <= 1'b0;
            if (axis != 2'd2) axis <= axis + 2'd1;
          end else phase <= 1'b1;
        end
      end
      vssc_pkg::ST_CHECK:
        if (!(inside_g && rdata) && !far) begin
          pos[pick] <= pos[pick] + 9'(stp[pick]);
          tmax[pick] <= tsum[TW] ? T_SAT : tsum[TW-1:0];
          left <= left - 6'd1;
        end
      vssc_pkg::ST_EMIT:
        if ((!out_valid || out_ready) && !far) begin
          pos[pick] <= pos[pick] + 9'(stp[pick]);
          tmax[pick] <= tsum[TW] ? T_SAT : tsum[TW-1:0];
          left <= left - 6'd1;
        end
      default: ;
    endcase
    if (state == vssc_pkg::ST_EMIT && (!out_valid || out_ready)) begin
      out_data.hit_x <= pos[0][7:0]; out_data.hit_y <= pos[1][7:0];
      out_data.hit_z <= pos[2][7:0]; out_data.is_hit <= 1'b1; out_data.last <= 1'b0;
    end else if (state == vssc_pkg::ST_MARK && (!out_valid || out_ready)) begin
      out_data <= '{hit_x: 8'sd0, hit_y: 8'sd0, hit_z: 8'sd0, is_hit: 1'b0, last: 1'b1};
    end
  end

`ifndef SYNTH
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready) else $error("input taken during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("output dropped");
  a_marker_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.is_hit != out_data.last) else $error("bad result flags");
`endif
endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the voxel segment tracer: occupancy writes, traced segments and a predictor.
`timescale 1ns / 1ps
`default_nettype none

class trace_scoreboard;
  localparam longint T_ONE = 64'd1 << 24;
  localparam longint T_SAT = (64'd1 << 32) - 1;
  bit occ[32768];
  vssc_pkg::out_item_t pending_hits[$];
  int mismatches;
  int checked;

  function bit solid_at(int x, int y, int z);
    if (x < 0 || x > 31 || y < 0 || y > 31 || z < 0 || z > 31) return 1'b0;
    return occ[(x << 10) | (y << 5) | z];
  endfunction

  function void push_result(int x, int y, int z, bit hit, bit fin);
    vssc_pkg::out_item_t r;
    r.hit_x = x[7:0];
    r.hit_y = y[7:0];
    r.hit_z = z[7:0];
    r.is_hit = hit;
    r.last = fin;
    pending_hits.push_back(r);
  endfunction

  function void note_input(vssc_pkg::in_item_t it);
    int s[3], e[3], c[3], dir[3];
    longint tm[3], td[3];
    longint ad, num;
    int lim, d, ax, n;
    if (it.func == vssc_pkg::FUNC_WRITE) begin
      occ[{it.cell_x, it.cell_y, it.cell_z}] = it.solid_bit;
      return;
    end
    lim = it.step_limit;
    s[0] = it.start_x; s[1] = it.start_y; s[2] = it.start_z;
    e[0] = it.end_x; e[1] = it.end_y; e[2] = it.end_z;
    for (int a = 0; a < 3; a++) c[a] = s[a] >>> 8;
    if (lim == 0 || (s[0] == e[0] && s[1] == e[1] && s[2] == e[2])) begin
      push_result(0, 0, 0, 1'b0, 1'b1);
      return;
    end
    for (int a = 0; a < 3; a++) begin
      d = e[a] - s[a];
      if (d == 0) begin
        dir[a] = 0; tm[a] = T_SAT; td[a] = T_SAT;
      end else begin
        if (d > 0) begin
          dir[a] = 1; ad = d; num = (c[a] + 1) * 256 - s[a];
        end else begin
          dir[a] = -1; ad = -d; num = s[a] - c[a] * 256;
        end
        tm[a] = (num << 24) / ad;
        if (tm[a] > T_SAT) tm[a] = T_SAT;
        td[a] = (longint'(256) << 24) / ad;
        if (td[a] > T_SAT) td[a] = T_SAT;
      end
    end
    for (n = 0; n < lim; n++) begin
      if (solid_at(c[0], c[1], c[2])) push_result(c[0], c[1], c[2], 1'b1, 1'b0);
      if (tm[0] < tm[1]) ax = (tm[0] < tm[2]) ? 0 : 2;
      else ax = (tm[1] < tm[2]) ? 1 : 2;
      if (tm[ax] > T_ONE) break;
      c[ax] += dir[ax];
      tm[ax] = tm[ax] + td[ax];
      if (tm[ax] > T_SAT) tm[ax] = T_SAT;
    end
    push_result(0, 0, 0, 1'b0, 1'b1);
  endfunction

  function void check_result(vssc_pkg::out_item_t got);
    vssc_pkg::out_item_t want;
    checked++;
    if (pending_hits.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_hits.pop_front();
    if (got.hit_x !== want.hit_x || got.hit_y !== want.hit_y || got.hit_z !== want.hit_z ||
        got.is_hit !== want.is_hit || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: expected x=%0d y=%0d z=%0d hit=%0b last=%0b",
                 want.hit_x, want.hit_y, want.hit_z, want.is_hit, want.last);
        $display("          got      x=%0d y=%0d z=%0d hit=%0b last=%0b",
                 got.hit_x, got.hit_y, got.hit_z, got.is_hit, got.last);
      end
    end
  endfunction
endclass

module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  vssc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vssc_pkg::out_item_t out_data;

  trace_scoreboard sb = new();
  int idle_cycles = 0;
  int traces_sent = 0;
  int writes_sent = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  voxel_segment_solid_cells u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) sb.note_input(in_data);
    if (out_valid && out_ready) sb.check_result(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("watchdog expired");
      $display("tb failed");
      $finish;
    end
  end

  // Receiver stall pattern, with one long hold-off window.
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (($urandom_range(0, 63) & 32) != 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_item(input vssc_pkg::in_item_t it);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    if (it.func == vssc_pkg::FUNC_WRITE) writes_sent++;
    else traces_sent++;
    @(negedge clk);
  endtask

  task automatic send_burst_item(input vssc_pkg::in_item_t it, input bit keep);
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (it.func == vssc_pkg::FUNC_WRITE) writes_sent++;
    else traces_sent++;
    if (!keep) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic vssc_pkg::in_item_t make_write(int x, int y, int z, bit v);
    vssc_pkg::in_item_t it;
    it = '0;
    it.start_x = 16'($urandom()); it.end_y = 16'($urandom());
    it.step_limit = 6'($urandom());
    it.func = vssc_pkg::FUNC_WRITE;
    it.cell_x = 5'(x); it.cell_y = 5'(y); it.cell_z = 5'(z); it.solid_bit = v;
    return it;
  endfunction

  function automatic vssc_pkg::in_item_t make_trace(int sx, int sy, int sz, int ex, int ey,
                                                    int ez, int lim);
    vssc_pkg::in_item_t it;
    it.func = vssc_pkg::FUNC_TRACE;
    it.cell_x = 5'($urandom()); it.cell_y = 5'($urandom()); it.cell_z = 5'($urandom());
    it.solid_bit = 1'($urandom());
    it.start_x = 16'(sx); it.start_y = 16'(sy); it.start_z = 16'(sz);
    it.end_x = 16'(ex); it.end_y = 16'(ey); it.end_z = 16'(ez);
    it.step_limit = 6'(lim);
    return it;
  endfunction

  function automatic int near_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 65535) - 32768;
    if (r == 1) return ($urandom_range(0, 3) - 1) * 256 * $urandom_range(0, 40);
    return $urandom_range(0, 36 * 256) - 2 * 256;
  endfunction

  function automatic vssc_pkg::in_item_t random_item();
    int sx, sy, sz;
    if ($urandom_range(0, 2) == 0)
      return make_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 3) != 0);
    sx = near_coord(); sy = near_coord(); sz = near_coord();
    case ($urandom_range(0, 5))
      0: return make_trace(sx, sy, sz, sx, sy, sz, $urandom_range(0, 63));
      1: return make_trace(sx, sy, sz, sx + $urandom_range(0, 4096) - 2048, sy, sz,
                           $urandom_range(0, 63));
      default: return make_trace(sx, sy, sz, near_coord(), near_coord(), near_coord(),
                                 ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 40));
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.pending_hits.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    int burst;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    // Directed part: map a line of solid cells and trace through it.
    for (int i = 0; i < 8; i++) send_item(make_write(i, 3, 4, 1'b1));
    send_item(make_write(31, 31, 31, 1'b1));
    send_item(make_write(0, 0, 0, 1'b1));
    send_item(make_write(2, 3, 4, 1'b0));
    send_item(make_trace(128, 3 * 256 + 128, 4 * 256 + 128, 10 * 256, 3 * 256 + 128,
                         4 * 256 + 128, 63));
    send_item(make_trace(9 * 256, 3 * 256 + 128, 4 * 256 + 128, -256, 3 * 256 + 128,
                         4 * 256 + 128, 63));
    send_item(make_trace(128, 3 * 256 + 128, 4 * 256 + 128, 10 * 256, 3 * 256, 4 * 256, 0));
    send_item(make_trace(300, 900, 1100, 300, 900, 1100, 63));
    send_item(make_trace(128, 128, 128, 32 * 256 - 1, 32 * 256 - 1, 32 * 256 - 1, 63));
    send_item(make_trace(0, 0, 0, 256, 256, 256, 63));
    send_item(make_trace(-32768, -32768, -32768, 32767, 32767, 32767, 63));
    send_item(make_trace(32767, 32767, 32767, -32768, -32768, -32768, 63));
    send_item(make_trace(31 * 256 + 128, 31 * 256 + 128, 31 * 256 + 128, 30 * 256, 31 * 256,
                         31 * 256 + 200, 5));
    send_item(make_trace(-256, 128, 128, 1024, 128, 128, 63));
    send_item(make_trace(128, 768 + 128, 1024 + 128, 128 + 1, 768 + 128, 1024 + 128, 1));
    send_item(make_write(31, 31, 31, 1'b0));
    wait_drained();
    // Long receiver hold-off while the sender keeps offering traces.
    fork
      begin
        hold_off = 1'b1;
        repeat (1500) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++)
          send_burst_item(make_trace(128, 3 * 256 + 128, 4 * 256 + 128, 12 * 256,
                                     3 * 256 + 128, 4 * 256 + 128, 63), i != 11);
      end
    join
    wait_drained();
    // Random part in bursts with gaps.
    while (writes_sent + traces_sent < 470) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) send_burst_item(random_item(), i != burst - 1);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 30)) @(negedge clk);
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
    wait_drained();
    $display("Covered %0d voxel writes and %0d segment traces; %0d results checked.",
             writes_sent, traces_sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_hits.size());
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
